// ===== hdl/mfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mfe_pkg
// Shared types, constants and CRC helpers for the token-bus frame encoder.
// ----------------------------------------------------------------------------
package mfe_pkg;

  localparam logic [7:0]  PREAMBLE_A   = 8'h55;
  localparam logic [7:0]  PREAMBLE_B   = 8'hFF;
  localparam logic [7:0]  HDR_CRC_INIT = 8'hFF;
  localparam logic [15:0] DATA_CRC_INIT = 16'hFFFF;
  localparam logic [15:0] DATA_CRC_POLY = 16'h8408;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  localparam int unsigned PADDR_W = 4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_FRAME_TYPE = 2'd0;
  localparam logic [1:0] REG_DEST_ADDR  = 2'd1;
  localparam logic [1:0] REG_SRC_ADDR   = 2'd2;

  typedef enum logic [3:0] {
    PH_PRE_A,
    PH_PRE_B,
    PH_TYPE,
    PH_DEST,
    PH_SRC,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_HCRC,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_e;

  // One classified input item: which sections of the frame it produces.
  typedef struct packed {
    logic        has_hdr;
    logic        has_data;
    logic        has_crc;
    logic [15:0] len;
    logic [7:0]  data;
    logic [15:0] crc;   // complemented CRC-16, ready for the wire
  } cmd_t;

  typedef struct packed {
    logic [2:0] frame_type;
    logic [7:0] dest_addr;
    logic [7:0] src_addr;
  } cfg_t;

  // Header CRC-8 update over one byte (closed form of the bitwise update).
  function automatic logic [7:0] hdr_crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [14:0] c;
    logic [14:0] acc;
    c   = {7'b0, crc ^ b};
    acc = c ^ (c << 1) ^ (c << 2) ^ (c << 3) ^ (c << 4) ^ (c << 5) ^ (c << 6) ^ (c << 7);
    return {acc[7:1], acc[8]};
  endfunction

  // Reflected CRC-16 update over one byte.
  function automatic logic [15:0] data_crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'b0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ DATA_CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/mfe_if.sv =====
// ----------------------------------------------------------------------------
// mfe_in_if / mfe_out_if
// Valid/ready channels for payload items in and encoded bytes out.
// ----------------------------------------------------------------------------
interface mfe_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] payload_len;
  logic        first_byte;
  logic        last_byte;
  logic        no_payload;

  modport source (output valid, output data_byte, output payload_len,
                  output first_byte, output last_byte, output no_payload,
                  input ready);
  modport sink   (input valid, input data_byte, input payload_len,
                  input first_byte, input last_byte, input no_payload,
                  output ready);
endinterface

interface mfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

// ===== hdl/mfe_front.sv =====
// ----------------------------------------------------------------------------
// mfe_front
// Accepts input items, tracks frame state and the running data CRC, and
// pushes one command per item that produces output.
// ----------------------------------------------------------------------------
module mfe_front
  import mfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  mfe_in_if.sink       in_i,
  input  logic         full_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  logic        in_frame_q, in_frame_d;
  logic [15:0] crc_q, crc_d;
  logic        accept;
  logic [15:0] crc_base;
  logic [15:0] crc_next;

  assign in_i.ready = ~full_i;
  assign accept     = in_i.valid & ~full_i;

  // A first byte restarts the CRC even inside an open frame.
  assign crc_base = in_i.first_byte ? DATA_CRC_INIT : crc_q;
  assign crc_next = data_crc_fold(crc_base, in_i.data_byte);

  always_comb begin
    in_frame_d = in_frame_q;
    crc_d      = crc_q;
    push_o     = 1'b0;
    cmd_o      = '{has_hdr: 1'b0, has_data: 1'b0, has_crc: 1'b0,
                   len: in_i.payload_len, data: in_i.data_byte, crc: ~crc_next};
    if (accept) begin
      priority if (in_i.no_payload) begin
        push_o       = 1'b1;
        cmd_o.has_hdr = 1'b1;
        cmd_o.has_crc = 1'b1;
        cmd_o.crc     = ~DATA_CRC_INIT;
        in_frame_d    = 1'b0;
        crc_d         = DATA_CRC_INIT;
      end else if (in_i.first_byte || in_frame_q) begin
        push_o         = 1'b1;
        cmd_o.has_hdr  = in_i.first_byte;
        cmd_o.has_data = 1'b1;
        cmd_o.has_crc  = in_i.last_byte;
        in_frame_d     = ~in_i.last_byte;
        crc_d          = in_i.last_byte ? DATA_CRC_INIT : crc_next;
      end else begin
        // Stray byte outside a frame: dropped.
        push_o = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      crc_q      <= DATA_CRC_INIT;
    end else begin
      in_frame_q <= in_frame_d;
      crc_q      <= crc_d;
    end
  end

endmodule

// ===== hdl/mfe_queue.sv =====
// ----------------------------------------------------------------------------
// mfe_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module mfe_queue
  import mfe_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  push_cmd_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output cmd_t  head_o
);

  cmd_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]     count_q;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/mfe_back.sv =====
// ----------------------------------------------------------------------------
// mfe_back
// Expands queued commands into wire bytes, one per cycle while the sink is ready,
// with the header CRC computed on the fly and an output register toward the sink.
// ----------------------------------------------------------------------------
module mfe_back
  import mfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       empty_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  mfe_out_if.source  out_o
);

  logic       active_q, active_d;
  phase_e     phase_q, phase_d;
  logic [7:0] hcrc_q, hcrc_d;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       end_q;

  phase_e     cur_phase;
  phase_e     nxt_phase;
  logic [7:0] cur_byte;
  logic       cur_end;
  logic       cur_last;
  logic       load;

  assign load = ~empty_i & (~valid_q | out_o.ready);

  always_comb begin
    if (active_q) begin
      cur_phase = phase_q;
    end else if (head_i.has_hdr) begin
      cur_phase = PH_PRE_A;
    end else if (head_i.has_data) begin
      cur_phase = PH_DATA;
    end else begin
      cur_phase = PH_CRC_LO;
    end
  end

  always_comb begin
    cur_byte  = PREAMBLE_A;
    cur_end   = 1'b0;
    cur_last  = 1'b0;
    nxt_phase = PH_PRE_A;
    unique case (cur_phase)
      PH_PRE_A: begin
        cur_byte  = PREAMBLE_A;
        nxt_phase = PH_PRE_B;
      end
      PH_PRE_B: begin
        cur_byte  = PREAMBLE_B;
        nxt_phase = PH_TYPE;
      end
      PH_TYPE: begin
        cur_byte  = {5'b0, cfg_i.frame_type};
        nxt_phase = PH_DEST;
      end
      PH_DEST: begin
        cur_byte  = cfg_i.dest_addr;
        nxt_phase = PH_SRC;
      end
      PH_SRC: begin
        cur_byte  = cfg_i.src_addr;
        nxt_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        cur_byte  = head_i.len[15:8];
        nxt_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        cur_byte  = head_i.len[7:0];
        nxt_phase = PH_HCRC;
      end
      PH_HCRC: begin
        cur_byte  = ~hcrc_q;
        cur_last  = ~head_i.has_data & ~head_i.has_crc;
        nxt_phase = head_i.has_data ? PH_DATA : PH_CRC_LO;
      end
      PH_DATA: begin
        cur_byte  = head_i.data;
        cur_last  = ~head_i.has_crc;
        nxt_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        cur_byte  = head_i.crc[7:0];
        nxt_phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        cur_byte  = head_i.crc[15:8];
        cur_end   = 1'b1;
        cur_last  = 1'b1;
        nxt_phase = PH_PRE_A;
      end
      default: begin
        cur_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    active_d = active_q;
    phase_d  = phase_q;
    hcrc_d   = hcrc_q;
    pop_o    = 1'b0;
    if (load) begin
      active_d = ~cur_last;
      phase_d  = nxt_phase;
      pop_o    = cur_last;
      // The header CRC covers type, addresses and length.
      if (cur_phase == PH_TYPE) begin
        hcrc_d = hdr_crc_fold(HDR_CRC_INIT, cur_byte);
      end else if (cur_phase == PH_DEST || cur_phase == PH_SRC ||
                   cur_phase == PH_LEN_HI || cur_phase == PH_LEN_LO) begin
        hcrc_d = hdr_crc_fold(hcrc_q, cur_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      phase_q  <= PH_PRE_A;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      phase_q  <= phase_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hcrc_q <= hcrc_d;
    if (load) begin
      byte_q <= cur_byte;
      end_q  <= cur_end;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.frame_end = end_q;

endmodule

// ===== hdl/mstp_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// mstp_frame_encoder
// Token-bus frame encoder: header, payload and CRC bytes onto a byte stream.
// ----------------------------------------------------------------------------
// Each accepted item turns into one wire byte mid-frame, so payload streams
// through at one item per cycle once the output side takes a byte per cycle.
// An item that opens a frame produces eight header bytes before its data
// byte, and a header-only request ten bytes in all; the output port emits one
// byte per cycle while the sink is ready; in those bursts the two-entry
// command queue fills and input ready drops until the back end pops a command.
// A byte passes through the command queue into the output register. The user
// must write the registers over APB at 0x0 (frame type), 0x4 (destination) and
// 0x8 (source) only while the encoder is idle; the block does not enforce it.
module mstp_frame_encoder
  import mfe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  mfe_in_if.sink             in_i,
  mfe_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg_q;
  logic cfg_we;
  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t push_cmd;
  cmd_t head;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_type <= 3'd5;
      cfg_q.dest_addr  <= 8'd0;
      cfg_q.src_addr   <= 8'd0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_FRAME_TYPE: cfg_q.frame_type <= pwdata[2:0];
        REG_DEST_ADDR:  cfg_q.dest_addr  <= pwdata[7:0];
        REG_SRC_ADDR:   cfg_q.src_addr   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_TYPE: prdata = {29'b0, cfg_q.frame_type};
      REG_DEST_ADDR:  prdata = {24'b0, cfg_q.dest_addr};
      REG_SRC_ADDR:   prdata = {24'b0, cfg_q.src_addr};
      default:        prdata = 32'b0;
    endcase
  end

  mfe_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  mfe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  mfe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== hdl/mfe_checker.sv =====
// ----------------------------------------------------------------------------
// mfe_checker
// Port-level checks on the frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module mfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       frame_end_i
);

  logic after_end_q;
  logic out_xfer;

  assign out_xfer = out_valid_i & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_end_q <= 1'b1;
    end else if (out_xfer) begin
      after_end_q <= frame_end_i;
    end
  end

  // A stalled output byte holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
                                    $stable(frame_end_i))
    else $error("output changed while stalled");

  // Once a frame has ended, the next byte on the wire opens a new header.
  a_new_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && after_end_q |-> out_byte_i == 8'h55)
    else $error("frame does not start with preamble");

  // Input only backs up when the output side has a byte pending.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no output pending");

  // The preamble's first byte is never marked as a frame end.
  a_end_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && after_end_q |-> !frame_end_i)
    else $error("frame end flagged on preamble");

endmodule

bind mstp_frame_encoder mfe_checker u_mfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .frame_end_i (out_o.frame_end)
);

// ===== verif/mstp_frame_encoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstp_frame_encoder_checker
// Watches the item, byte and APB ports of the frame encoder, works out the
// wire bytes each accepted item must produce and compares them in order.
// ----------------------------------------------------------------------------
module mstp_frame_encoder_checker
  import mfe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  mfe_in_if                  in_i,
  mfe_out_if                 out_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct {
    logic [7:0] value;
    logic       last;
  } wire_byte_t;

  wire_byte_t  wire_q[$];
  cfg_t        cfg;
  logic [15:0] run_crc;
  logic        open_frame;
  int          n_mismatch = 0;
  int          n_pending  = 0;

  assign fail_count_o = n_mismatch;
  assign pending_o    = n_pending;

  // Header CRC-8: multiply by the all-ones pattern, then rotate bit 8 into bit 0.
  function automatic logic [7:0] header_crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [15:0] prod;
    logic [7:0]  x;
    x    = crc ^ b;
    prod = '0;
    for (int k = 0; k < 8; k++) begin
      prod = prod ^ ({8'h00, x} << k);
    end
    return {prod[7:1], prod[8]};
  endfunction

  // Reflected CRC-16, one input bit at a time, least significant bit first.
  function automatic logic [15:0] payload_crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = c >> 1;
      if (fb) begin
        c = c ^ 16'h8408;
      end
    end
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] value, input logic last);
    wire_byte_t wb;
    wb.value = value;
    wb.last  = last;
    wire_q.push_back(wb);
  endtask

  task automatic push_header(input logic [15:0] len);
    logic [7:0] field [5];
    logic [7:0] crc;
    field[0] = {5'd0, cfg.frame_type};
    field[1] = cfg.dest_addr;
    field[2] = cfg.src_addr;
    field[3] = len[15:8];
    field[4] = len[7:0];
    crc = HDR_CRC_INIT;
    push_byte(PREAMBLE_A, 1'b0);
    push_byte(PREAMBLE_B, 1'b0);
    for (int k = 0; k < 5; k++) begin
      crc = header_crc_step(crc, field[k]);
      push_byte(field[k], 1'b0);
    end
    push_byte(~crc, 1'b0);
  endtask

  // The trailer goes out complemented, low byte first; its high byte ends the frame.
  task automatic push_trailer(input logic [15:0] crc);
    logic [15:0] inv;
    inv = ~crc;
    push_byte(inv[7:0], 1'b0);
    push_byte(inv[15:8], 1'b1);
  endtask

  task automatic encode_item(input logic [7:0] b, input logic [15:0] len, input logic first,
                             input logic last, input logic nopay);
    if (nopay) begin
      push_header(len);
      push_trailer(DATA_CRC_INIT);
      run_crc    = DATA_CRC_INIT;
      open_frame = 1'b0;
    end else begin
      if (first) begin
        push_header(len);
        run_crc    = DATA_CRC_INIT;
        open_frame = 1'b1;
      end
      // A byte with no open frame is dropped without a trace.
      if (open_frame) begin
        push_byte(b, 1'b0);
        run_crc = payload_crc_step(run_crc, b);
        if (last) begin
          push_trailer(run_crc);
          run_crc    = DATA_CRC_INIT;
          open_frame = 1'b0;
        end
      end
    end
  endtask

  task automatic record_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    case (addr[3:2])
      REG_FRAME_TYPE: begin
        cfg.frame_type = data[2:0];
      end
      REG_DEST_ADDR: begin
        cfg.dest_addr = data[7:0];
      end
      REG_SRC_ADDR: begin
        cfg.src_addr = data[7:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_byte(input logic [7:0] value, input logic last);
    wire_byte_t want;
    if (wire_q.size() == 0) begin
      $display("%0t ns: unexpected byte: expected none, actual out_byte=%02h frame_end=%0b",
               $time, value, last);
      n_mismatch++;
    end else begin
      want = wire_q.pop_front();
      if (want.value !== value) begin
        $display("%0t ns: out_byte mismatch: expected %02h, actual %02h",
                 $time, want.value, value);
        n_mismatch++;
      end
      if (want.last !== last) begin
        $display("%0t ns: frame_end mismatch: expected %0b, actual %0b",
                 $time, want.last, last);
        n_mismatch++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.frame_type = 3'd5;
      cfg.dest_addr  = 8'd0;
      cfg.src_addr   = 8'd0;
      run_crc        = DATA_CRC_INIT;
      open_frame     = 1'b0;
      wire_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        record_write(paddr, pwdata);
      end
      if (in_i.valid && in_i.ready) begin
        encode_item(in_i.data_byte, in_i.payload_len, in_i.first_byte, in_i.last_byte,
                    in_i.no_payload);
      end
      if (out_i.valid && out_i.ready) begin
        check_byte(out_i.out_byte, out_i.frame_end);
      end
    end
    n_pending = wire_q.size();
  end

endmodule

// ===== verif/mstp_frame_encoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstp_frame_encoder_test
// Drives payload items and APB register writes into the frame encoder with
// random gaps and output stalls; the checker beside it predicts every wire
// byte and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module mstp_frame_encoder_test;
  import mfe_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic sink_ready = 1'b0;
  logic src_idle   = 1'b0;
  logic sink_idle  = 1'b0;
  int   sink_wait  = 0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   pending;

  mfe_in_if  in_if ();
  mfe_out_if out_if ();

  assign out_if.ready = sink_ready;

  mstp_frame_encoder u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mstp_frame_encoder_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #2 clk_i = ~clk_i;

  // Byte sink: after each transfer it may hold ready low while a randomly drawn wait counts down.
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      sink_wait <= sink_idle ? $urandom_range(0, 9) : 0;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
    end
  end

  always @(negedge clk_i) begin
    sink_ready <= (sink_wait == 0);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_item(input logic [7:0] b, input logic [15:0] len, input logic first,
                           input logic last, input logic nopay);
    int gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.payload_len <= len;
    in_if.first_byte  <= first;
    in_if.last_byte   <= last;
    in_if.no_payload  <= nopay;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stop sending and let every expected byte drain.
  task automatic drain;
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic send_frame(input int n, input logic close);
    logic [15:0] len;
    len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) : 16'(n);
    for (int k = 0; k < n; k++) begin
      push_item(8'($urandom_range(0, 255)),
                (k == 0) ? len : 16'($urandom_range(0, 65535)),
                k == 0, close && (k == n - 1), 1'b0);
    end
  endtask

  task automatic random_traffic(input int target);
    int sent;
    int pick;
    int n;
    sent = 0;
    while (sent < target) begin
      pick      = $urandom_range(0, 99);
      src_idle  = ($urandom_range(0, 2) != 0);
      sink_idle = ($urandom_range(0, 2) != 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if (pick < 70) begin
        send_frame(n, 1'b1);
        sent += n;
      end else if (pick < 80) begin
        push_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  1'($urandom), 1'($urandom), 1'b1);
        sent++;
      end else if (pick < 88) begin
        // Frame cut short: the next start or header-only request abandons it.
        send_frame(n, 1'b0);
        sent += n;
      end else if (pick < 94) begin
        push_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  1'b0, 1'($urandom), 1'b0);
      end else begin
        push_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  1'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.data_byte   = '0;
    in_if.payload_len = '0;
    in_if.first_byte  = 1'b0;
    in_if.last_byte   = 1'b0;
    in_if.no_payload  = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items under the reset register values.
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    push_item(8'h00, 16'h0000, 1'b0, 1'b0, 1'b1);   // header-only, zero length
    push_item(8'hAA, 16'hFFFF, 1'b1, 1'b1, 1'b1);   // header-only beats first and last
    push_item(8'h12, 16'h1234, 1'b0, 1'b0, 1'b0);   // stray byte, dropped
    push_item(8'h34, 16'h0000, 1'b0, 1'b1, 1'b0);   // stray last byte, dropped
    push_item(8'h00, 16'h0001, 1'b1, 1'b1, 1'b0);   // one-byte frame
    push_item(8'hFF, 16'h0003, 1'b1, 1'b0, 1'b0);
    push_item(8'h80, 16'hABCD, 1'b0, 1'b0, 1'b0);
    push_item(8'h01, 16'h5555, 1'b0, 1'b1, 1'b0);
    push_item(8'h5A, 16'h0002, 1'b1, 1'b0, 1'b0);
    push_item(8'hA5, 16'h8000, 1'b1, 1'b0, 1'b0);   // restart inside an open frame
    push_item(8'hC3, 16'h0000, 1'b0, 1'b1, 1'b0);
    push_item(8'h11, 16'h00FF, 1'b1, 1'b0, 1'b0);
    push_item(8'h22, 16'h0100, 1'b0, 1'b0, 1'b1);   // header-only abandons the open frame
    push_item(8'h77, 16'h7FFF, 1'b0, 1'b1, 1'b0);   // dropped: frame already closed
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    push_item(8'h7F, 16'hFFFE, 1'b1, 1'b1, 1'b0);
    push_item(8'hFE, 16'h0000, 1'b1, 1'b0, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          apb_write(REG_FRAME_TYPE, 32'd0);
          apb_write(REG_DEST_ADDR, 32'd0);
          apb_write(REG_SRC_ADDR, 32'd0);
        end
        1: begin
          apb_write(REG_FRAME_TYPE, 32'd7);
          apb_write(REG_DEST_ADDR, 32'd255);
          apb_write(REG_SRC_ADDR, 32'd254);
        end
        default: begin
          apb_write(REG_FRAME_TYPE, $urandom_range(0, 7));
          apb_write(REG_DEST_ADDR, $urandom_range(0, 255));
          apb_write(REG_SRC_ADDR, $urandom_range(0, 254));
        end
      endcase
      random_traffic(75);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
